// File: src/lsf_pkg.sv
package lsf_pkg;

  // field widths fixed by the interface
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 16;
  localparam int PIXIDX_W = 6;
  localparam int LEVEL_W  = 8;
  localparam int PROD_W   = 2 * CNT_W;
  localparam int UNIT_W   = PROD_W + LEVEL_W;

  // register reset values
  localparam logic [CNT_W-1:0] SPAWN_PERIOD_RST  = 16'd5;
  localparam logic [CNT_W-1:0] FADE_DURATION_RST = 16'd300;

  // configuration register indexes
  localparam logic REG_SPAWN_PERIOD  = 1'b0;
  localparam logic REG_FADE_DURATION = 1'b1;

  // quotient bit steps of the fade division (top step is the saturation test) and of the spawn remainder
  localparam logic [4:0] FADE_TOP_STEP = 5'd8;
  localparam logic [4:0] MOD_TOP_STEP  = 5'd31;

  typedef struct packed {
    logic [TIME_W-1:0]   time_ms;
    logic [CNT_W-1:0]    elapsed_ms;
    logic [PIXIDX_W-1:0] random_pixel;
  } lsf_in_t;

  typedef struct packed {
    logic [PIXIDX_W-1:0] pixel_index;
    logic [LEVEL_W-1:0]  brightness;
    logic                last_pixel;
  } lsf_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN,
    ST_MOD,
    ST_SP_RD,
    ST_SP_WR,
    ST_PIX_RD,
    ST_PIX_UPD,
    ST_MUL,
    ST_SCALE,
    ST_FDIV,
    ST_EMIT
  } lsf_state_t;

endpackage

// File: src/lsf_ram.sv
module lsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/led_sparkle_fade.sv
// led_sparkle_fade: per-frame sparkle generator with a quadratic ease-out fade
//
// in channel: one word per frame tick (time_ms, elapsed_ms, random_pixel),
//   taken when in_valid and in_ready are both high; in_ready is high only
//   while no frame is being worked on
// out channel: PIXEL_COUNT words per frame, pixel 0 first, last_pixel set on
//   the final one; a single output register sits between the pixel walk and
//   the receiver, so the walk keeps going while one word waits
// cfg channel: cfg_index 0 = spawn period, 1 = fade duration; cfg_ready is
//   always high, write only between frames
// timing: a frame squares the duration, then works out the spawn remainder
//   bit by bit (skipped when the spawn period is zero), then lets a spawn
//   load when it may; per pixel it reads and updates the countdown and, when
//   lit, squares, scales and divides (stopping at the top step when the level
//   saturates) before emitting; the shared 40 bit subtract/compare unit carries
//   the remainder, the x255 scaling and the quotient bits one step a cycle
// stall: when the receiver holds out_ready low, the walk parks with its
//   next word done until the output register frees
// reset: rst_n is synchronous; countdowns read as zero through per-pixel
//   valid bits cleared at once, registers go back to 5 ms and 300 ms
module led_sparkle_fade #(
  parameter int PIXEL_COUNT = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lsf_pkg::lsf_in_t       in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lsf_pkg::lsf_out_t      out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [lsf_pkg::CNT_W-1:0] cfg_wdata
);
  import lsf_pkg::*;

  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXEL_COUNT - 1);

  // state and registers
  lsf_state_t state_r, state_nxt;

  logic [CNT_W-1:0]    spawn_r, fade_r;
  logic [TIME_W-1:0]   tim_r, tim_nxt;
  logic [CNT_W-1:0]    dt_r, dt_nxt;
  logic [PIXIDX_W-1:0] pix_r, pix_nxt;
  logic [AW-1:0]       l_r, l_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [UNIT_W-1:0]   rem_r, rem_nxt;
  logic [PROD_W-1:0]   den_r, den_nxt;
  logic [CNT_W-1:0]    diff_r, diff_nxt;
  logic [LEVEL_W-1:0]  q_r, q_nxt;
  logic                out_valid_r, out_valid_nxt;
  lsf_out_t            out_data_r, out_data_nxt;
  logic [PIXEL_COUNT-1:0] vld_r, vld_nxt;

  // countdown memory
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [CNT_W-1:0] ram_wdata, ram_rdata;

  lsf_ram #(
    .WIDTH (CNT_W),
    .DEPTH (PIXEL_COUNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared subtract/compare unit
  logic [UNIT_W-1:0] unit_a, unit_b, unit_diff;
  logic              unit_borrow, unit_geq;

  assign {unit_borrow, unit_diff} = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_geq = !unit_borrow;

  // shared 16x16 multiplier
  logic [CNT_W-1:0]  mul_op;
  logic [PROD_W-1:0] mul_prod;

  assign mul_prod = PROD_W'(mul_op) * PROD_W'(mul_op);

  // misc decode
  logic             in_acc, emit_go, is_last, spawn_ok, mod_zero;
  logic [AW-1:0]    pix_addr, cur_addr;
  logic [CNT_W-1:0] cur_cnt, new_cnt;
  logic             live;

  assign in_acc    = in_valid && in_ready;
  assign emit_go   = !out_valid_r || out_ready;
  assign is_last   = (l_r == LAST_ADDR);
  assign pix_addr  = pix_r[AW-1:0];
  assign spawn_ok  = ({1'b0, pix_r} < 7'(PIXEL_COUNT));
  assign mod_zero  = (unit_geq ? unit_diff[CNT_W-1:0] : unit_a[CNT_W-1:0]) == '0;
  assign cur_addr  = (state_r == ST_SP_WR) ? pix_addr : l_r;
  assign cur_cnt   = vld_r[cur_addr] ? ram_rdata : '0;
  assign live      = cur_cnt > dt_r;
  assign new_cnt   = cur_cnt - dt_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DEN;
        end
      end
      ST_DEN: begin
        state_nxt = (spawn_r != '0) ? ST_MOD : ST_PIX_RD;
      end
      ST_MOD: begin
        if (cnt_r == '0) begin
          state_nxt = (mod_zero && spawn_ok) ? ST_SP_RD : ST_PIX_RD;
        end
      end
      ST_SP_RD:   state_nxt = ST_SP_WR;
      ST_SP_WR:   state_nxt = ST_PIX_RD;
      ST_PIX_RD:  state_nxt = ST_PIX_UPD;
      ST_PIX_UPD: begin
        state_nxt = (live && fade_r != '0) ? ST_MUL : ST_EMIT;
      end
      ST_MUL:     state_nxt = ST_SCALE;
      ST_SCALE:   state_nxt = ST_FDIV;
      ST_FDIV: begin
        if ((cnt_r == FADE_TOP_STEP && unit_geq) || cnt_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = is_last ? ST_IDLE : ST_PIX_RD;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = l_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = l_r;
    unit_a    = '0;
    unit_b    = '0;
    mul_op    = diff_r;
    case (state_r)
      ST_DEN: begin
        mul_op = fade_r;
      end
      ST_MOD: begin
        unit_a = {23'd0, rem_r[CNT_W-1:0], tim_r[TIME_W-1]};
        unit_b = UNIT_W'(spawn_r);
      end
      ST_SP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pix_addr;
      end
      ST_SP_WR: begin
        ram_we    = (cur_cnt == '0);
        ram_waddr = pix_addr;
        ram_wdata = fade_r;
      end
      ST_PIX_RD: begin
        ram_re = 1'b1;
      end
      ST_PIX_UPD: begin
        ram_we    = 1'b1;
        ram_wdata = live ? new_cnt : '0;
      end
      ST_SCALE: begin
        // x255 as x256 minus x1
        unit_a = {rem_r[PROD_W-1:0], 8'd0};
        unit_b = UNIT_W'(rem_r[PROD_W-1:0]);
      end
      ST_FDIV: begin
        unit_a = rem_r;
        unit_b = UNIT_W'(den_r) << cnt_r[3:0];
      end
      default: begin
      end
    endcase
  end

  // register next values
  always_comb begin
    tim_nxt       = tim_r;
    dt_nxt        = dt_r;
    pix_nxt       = pix_r;
    l_nxt         = l_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    diff_nxt      = diff_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    vld_nxt       = vld_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (ram_we) begin
      vld_nxt[ram_waddr] = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          tim_nxt = in_data.time_ms;
          dt_nxt  = in_data.elapsed_ms;
          pix_nxt = in_data.random_pixel;
          l_nxt   = '0;
          cnt_nxt = MOD_TOP_STEP;
          rem_nxt = '0;
        end
      end
      ST_DEN: begin
        den_nxt = mul_prod;
      end
      ST_MOD: begin
        // one remainder bit per cycle, time word shifts out msb first
        rem_nxt = unit_geq ? unit_diff : unit_a;
        tim_nxt = tim_r << 1;
        cnt_nxt = cnt_r - 5'd1;
      end
      ST_PIX_UPD: begin
        q_nxt = '0;
        if (new_cnt >= fade_r) begin
          diff_nxt = new_cnt - fade_r;
        end else begin
          diff_nxt = fade_r - new_cnt;
        end
      end
      ST_MUL: begin
        rem_nxt = UNIT_W'(mul_prod);
      end
      ST_SCALE: begin
        rem_nxt = unit_diff;
        cnt_nxt = FADE_TOP_STEP;
      end
      ST_FDIV: begin
        if (cnt_r == FADE_TOP_STEP && unit_geq) begin
          q_nxt = '1;
        end else begin
          q_nxt   = {q_r[LEVEL_W-2:0], unit_geq};
          rem_nxt = unit_geq ? unit_diff : unit_a;
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.pixel_index = PIXIDX_W'(l_r);
          out_data_nxt.brightness  = q_r;
          out_data_nxt.last_pixel  = is_last;
          if (!is_last) begin
            l_nxt = l_r + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      spawn_r     <= SPAWN_PERIOD_RST;
      fade_r      <= FADE_DURATION_RST;
      l_r         <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      l_r         <= l_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPAWN_PERIOD:  spawn_r <= cfg_wdata;
          REG_FADE_DURATION: fade_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tim_r      <= tim_nxt;
    dt_r       <= dt_nxt;
    pix_r      <= pix_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    diff_r     <= diff_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // a frame starts with the duration square
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_DEN)
    else $error("frame did not start after accept");

  // fade division never shifts the divisor past the saturation step
  a_fdiv_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FDIV |-> cnt_r <= FADE_TOP_STEP)
    else $error("fade step out of range");

  // the last pixel word closes the frame
  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && emit_go && is_last)
      |=> (state_r == ST_IDLE && out_valid_r && out_data_r.last_pixel))
    else $error("frame did not close on last pixel");

  // countdowns only change during a frame
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !ram_we)
    else $error("countdown written while idle");
`endif

endmodule

// File: tb/sv/lsf_checker.sv
`timescale 1ns / 100ps

module lsf_checker #(
  parameter int PIXEL_COUNT = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  lsf_pkg::lsf_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  lsf_pkg::lsf_out_t         out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [lsf_pkg::CNT_W-1:0] cfg_wdata,
  output int                        errors,
  output int                        words_due,
  output int                        frames,
  output int                        words_checked,
  output int                        lit_words,
  output int                        reg_writes
);
  import lsf_pkg::*;

  // shadow of the registers and the per-pixel countdowns
  logic [CNT_W-1:0] spawn_ms;
  logic [CNT_W-1:0] fade_ms;
  logic [CNT_W-1:0] sparkle_left [PIXEL_COUNT];
  lsf_out_t         pixel_words_q [$];
  lsf_out_t         want;

  // floor(255 * (span - left)^2 / span^2), saturated at full scale
  function automatic logic [LEVEL_W-1:0] ease_level(input logic [CNT_W-1:0] left,
                                                    input logic [CNT_W-1:0] span);
    logic [63:0] gap;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    if (span == '0) return '0;
    gap = (left > span) ? 64'(left - span) : 64'(span - left);
    num = 64'd255 * gap * gap;
    den = 64'(span);
    den = den * den;
    q   = num / den;
    return (q > 64'd255) ? 8'd255 : q[LEVEL_W-1:0];
  endfunction

  // one frame tick: maybe start a sparkle, then walk every pixel
  task automatic walk_frame(input lsf_in_t w);
    logic [CNT_W-1:0] left;
    lsf_out_t         word;
    if (spawn_ms != '0 && (w.time_ms % spawn_ms) == 0 && w.random_pixel < PIXEL_COUNT) begin
      if (sparkle_left[w.random_pixel] == '0) sparkle_left[w.random_pixel] = fade_ms;
    end
    for (int p = 0; p < PIXEL_COUNT; p++) begin
      left = sparkle_left[p];
      word.pixel_index = PIXIDX_W'(p);
      word.last_pixel  = (p == PIXEL_COUNT - 1);
      if (left > w.elapsed_ms) begin
        left            = left - w.elapsed_ms;
        word.brightness = ease_level(left, fade_ms);
      end else begin
        left            = '0;
        word.brightness = '0;
      end
      sparkle_left[p] = left;
      if (word.brightness != '0) lit_words++;
      pixel_words_q.push_back(word);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      spawn_ms = SPAWN_PERIOD_RST;
      fade_ms  = FADE_DURATION_RST;
      foreach (sparkle_left[i]) sparkle_left[i] = '0;
      pixel_words_q.delete();
      errors        = 0;
      frames        = 0;
      words_checked = 0;
      lit_words     = 0;
      reg_writes    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        if (cfg_index == REG_SPAWN_PERIOD) spawn_ms = cfg_wdata;
        else fade_ms = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        frames++;
        walk_frame(in_data);
      end
      if (out_valid && out_ready) begin
        if (pixel_words_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel word, got idx %0d level %0d last %0b",
                   $time, out_data.pixel_index, out_data.brightness, out_data.last_pixel);
        end else begin
          want = pixel_words_q.pop_front();
          words_checked++;
          if (out_data.pixel_index !== want.pixel_index ||
              out_data.brightness !== want.brightness ||
              out_data.last_pixel !== want.last_pixel) begin
            errors++;
            $display({"%0t: pixel word mismatch, expected idx %0d level %0d last %0b,",
                      " got idx %0d level %0d last %0b"},
                     $time, want.pixel_index, want.brightness, want.last_pixel,
                     out_data.pixel_index, out_data.brightness, out_data.last_pixel);
          end
        end
      end
    end
    words_due = pixel_words_q.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lsf_pkg::*;

  localparam int PIXEL_COUNT = 64;
  // cycles without any accepted word before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  // settle time after the last pixel word, about one lit pixel plus margin
  localparam int TAIL_CYCLES = 64;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  lsf_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  lsf_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [CNT_W-1:0] cfg_wdata;

  int errors;
  int words_due;
  int frames;
  int words_checked;
  int lit_words;
  int reg_writes;

  // idle odds in percent per cycle for the frame sender and the pixel receiver
  int tx_idle_pct;
  int rx_idle_pct;
  int stall_cycles;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  led_sparkle_fade #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predicts every pixel word from the observed frames and register writes
  lsf_checker #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .words_due     (words_due),
    .frames        (frames),
    .words_checked (words_checked),
    .lit_words     (lit_words),
    .reg_writes    (reg_writes)
  );

  // receiver backpressure, rerolled every cycle at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // hang detection: any accepted word on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout: %0d cycles with no word accepted, %0d pixel words still due",
             stall_cycles, words_due);
    $display("Simulation FAILED");
    $finish;
  end

  // one frame tick; valid stays up from the previous frame unless the sender idles,
  // so valid is never dropped and raised within the same falling edge
  task automatic send_frame(input logic [TIME_W-1:0]   t,
                            input logic [CNT_W-1:0]    dt,
                            input logic [PIXIDX_W-1:0] pix);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= lsf_in_t'{time_ms: t, elapsed_ms: dt, random_pixel: pix};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // both registers are rewritten only once every predicted pixel word is back,
  // with no frame offered meanwhile
  task automatic apply_settings(input logic [CNT_W-1:0] spawn, input logic [CNT_W-1:0] fade);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (words_due == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SPAWN_PERIOD;
    cfg_wdata <= spawn;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_FADE_DURATION;
    cfg_wdata <= fade;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CNT_W-1:0]    spawn_v;
    logic [CNT_W-1:0]    fade_v;
    logic [TIME_W-1:0]   t_v;
    logic [CNT_W-1:0]    dt_v;
    longint unsigned     multiple;
    int                  step_lim;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_SPAWN_PERIOD;
    cfg_wdata   = '0;
    out_ready   = 1'b0;
    tx_idle_pct = 7;
    rx_idle_pct = 50;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part, reset settings first (spawn every 5 ms, 300 ms fade)
    // time zero spawns on pixel 0, fresh sparkle is still dark
    send_frame(32'd0, 16'd0, 6'd0);
    // top pixel index spawns, first step of the fade
    send_frame(32'd5, 16'd1, 6'd63);
    // time off the spawn grid, no load
    send_frame(32'd7, 16'd100, 6'd1);
    // largest time is a multiple of 5, but pixel 63 is busy so it is not reloaded
    send_frame(32'hFFFF_FFFF, 16'd0, 6'd63);
    // largest elapsed time clears everything, including a sparkle just started
    send_frame(32'd10, 16'hFFFF, 6'd42);
    // elapsed equal to the countdown clears it
    send_frame(32'd15, 16'd300, 6'd5);
    // one ms left, nearly full brightness
    send_frame(32'd20, 16'd299, 6'd6);

    // spawn every ms, longest fade
    apply_settings(16'd1, 16'hFFFF);
    send_frame(32'hFFFF_FFFF, 16'd0, 6'd21);
    send_frame(32'd1, 16'd1, 6'd42);
    send_frame(32'd2, 16'd32768, 6'd0);

    // shortest fade under live long countdowns: level saturates
    apply_settings(16'd1, 16'd1);
    send_frame(32'd3, 16'd1, 6'd10);
    send_frame(32'd4, 16'd0, 6'd11);

    // zero fade: countdowns keep running but stay dark, spawns load zero
    apply_settings(16'd1, 16'd0);
    send_frame(32'd5, 16'd5, 6'd12);

    // zero spawn period: nothing ever loads, even at time zero
    apply_settings(16'd0, 16'd300);
    send_frame(32'd0, 16'd0, 6'd13);
    send_frame(32'h8000_0000, 16'h7FFF, 6'd14);

    // longest spawn period, times on and off its grid
    apply_settings(16'hFFFF, 16'd300);
    send_frame(32'd196605, 16'd10, 6'd30);
    send_frame(32'hFFFF_FFFF, 16'd10, 6'd31);
    send_frame(32'd65536, 16'd0, 6'd32);

    // --- random part: three idle patterns, three register settings each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 7;
          rx_idle_pct = 50;
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 7;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < 3; chunk++) begin
        case ($urandom_range(5))
          0:       spawn_v = 16'd1;
          1:       spawn_v = 16'hFFFF;
          2:       spawn_v = 16'd0;
          default: spawn_v = CNT_W'($urandom_range(2, 12));
        endcase
        case ($urandom_range(5))
          0:       fade_v = 16'd1;
          1:       fade_v = 16'hFFFF;
          2:       fade_v = 16'd0;
          default: fade_v = CNT_W'($urandom_range(20, 3000));
        endcase
        apply_settings(spawn_v, fade_v);
        // elapsed mostly a fraction of the fade so sparkles live for several frames
        step_lim = int'(fade_v) / 5 + 1;
        for (int n = 0; n < 29; n++) begin
          // mostly times on the spawn grid so sparkles actually start
          if (spawn_v != '0 && $urandom_range(3) != 0) begin
            multiple = $urandom % (64'h1_0000_0000 / spawn_v);
            t_v      = TIME_W'(multiple * spawn_v);
          end else begin
            t_v = $urandom;
          end
          case ($urandom_range(9))
            0:       dt_v = CNT_W'($urandom_range(0, 65535));
            1:       dt_v = '0;
            default: dt_v = CNT_W'($urandom_range(0, step_lim));
          endcase
          send_frame(t_v, dt_v, PIXIDX_W'($urandom_range(0, 63)));
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (words_due == 0);
    // watch for stray words after the last frame
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d frames, %0d pixel words checked (%0d lit), %0d register writes",
             frames, words_checked, lit_words, reg_writes);
    $display("spawn and fade extremes, zero settings and saturation under three idle patterns");
    if (errors == 0 && words_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d pixel words never arrived", errors, words_due);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/lsf_pkg.sv
src/lsf_ram.sv
src/led_sparkle_fade.sv
tb/sv/lsf_checker.sv
tb/sv/testbench.sv
